@@ rtl/rsm_pkg.sv @@
// Shared types and constants of the streaming pattern matcher.
package rsm_pkg;

    // Pattern symbol codes
    localparam logic [7:0] SYM_ANY  = 8'h2E;  // '.'
    localparam logic [7:0] SYM_STAR = 8'h2A;  // '*'
    localparam logic [7:0] SYM_OPT  = 8'h3F;  // '?'
    localparam logic [7:0] SYM_PLUS = 8'h2B;  // '+'

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 64;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_SYMBOLS = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH  = 1'b1;

    localparam int STORED_SYMBOLS = 8;   // bytes held in pattern_symbols
    localparam int LENGTH_BITS    = 4;
    localparam int START_BITS     = 16;

    typedef struct packed {
        logic [7:0] text_char;
        logic       start_of_text;
    } t_rsm_in;

    typedef struct packed {
        logic                  match_found;
        logic [START_BITS-1:0] match_start;
        logic                  first_match_res;
    } t_rsm_out;

    // Per-cell view of the pattern
    typedef struct packed {
        logic [7:0] sym;       // symbol at this position
        logic [7:0] base;      // symbol before it, base of a quantifier
        logic       quant_ok;  // a quantifier here is honoured
        logic       enable;    // position lies within the pattern length
    } t_rsm_sym;

endpackage

@@ rtl/rsm_cell.sv @@
// One pattern position: holds its earliest partial-match start and updates it per byte.
module rsm_cell #(
    parameter int POS_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_clear,
    input  rsm_pkg::t_rsm_sym    i_sym,
    input  logic [7:0]           i_char,
    input  logic [POS_BITS:0]    i_p1,     // previous row, closed, column j-1
    input  logic [POS_BITS:0]    i_p2,     // previous row, closed, column j-2
    input  logic [POS_BITS:0]    i_c2,     // current row, column j-2
    output logic [POS_BITS:0]    o_closed, // previous row, closed, this column
    output logic [POS_BITS:0]    o_cur     // current row, this column
);
    import rsm_pkg::*;

    logic                r_valid;
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS:0]   w_self;
    logic                w_star, w_opt, w_plus, w_quant, w_base_hit;

    // Keep the valid one, or the earlier start when both are valid
    function automatic logic [POS_BITS:0] merge(input logic [POS_BITS:0] a,
                                                input logic [POS_BITS:0] b);
        logic [POS_BITS:0] res;
        res = a;
        if (b[POS_BITS] && (!a[POS_BITS] || b[POS_BITS-1:0] < a[POS_BITS-1:0]))
            res = b;
        return res;
    endfunction

    assign w_self     = i_clear ? '0 : {r_valid, r_pos};
    assign w_star     = (i_sym.sym == SYM_STAR);
    assign w_opt      = (i_sym.sym == SYM_OPT);
    assign w_plus     = (i_sym.sym == SYM_PLUS);
    assign w_quant    = i_sym.quant_ok && (w_star || w_opt || w_plus);
    assign w_base_hit = (i_sym.base == SYM_ANY) || (i_sym.base == i_char);

    always_comb begin
        o_closed = w_self;
        if (i_sym.enable && w_quant && (w_star || w_opt))
            o_closed = merge(w_self, i_p2);
    end

    always_comb begin
        o_cur = '0;
        if (i_sym.enable) begin
            if (!w_quant) begin
                if ((i_sym.sym == SYM_ANY) || (i_sym.sym == i_char))
                    o_cur = i_p1;
            end else if (w_star) begin
                o_cur = i_c2;
                if (w_base_hit)
                    o_cur = merge(i_c2, o_closed);
            end else if (w_opt) begin
                o_cur = i_c2;
                if (w_base_hit)
                    o_cur = merge(i_c2, i_p2);
            end else if (w_base_hit) begin
                o_cur = merge(i_p2, o_closed);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            r_valid <= o_cur[POS_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pos <= o_cur[POS_BITS-1:0];
        end
    end

endmodule

@@ rtl/rsm_out_buf.sv @@
// Two-entry output buffer: holds results while the receiver stalls.
module rsm_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rsm_pkg::t_rsm_out i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output rsm_pkg::t_rsm_out o_data
);
    import rsm_pkg::*;

    logic     r_out_valid, r_skid_valid;
    t_rsm_out r_out, r_skid;
    logic     w_push, w_pop;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;
    assign w_push  = i_valid && !r_skid_valid;
    assign w_pop   = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_push) begin
                r_out <= i_data;
            end
        end else if (w_push) begin
            if (r_out_valid) begin
                r_skid <= i_data;
            end else begin
                r_out <= i_data;
            end
        end
    end

endmodule

@@ rtl/regex_substring_match.sv @@
// Top level of the streaming pattern matcher: register file, cell row and output buffer.
//
// Usage:
//   Write pattern_symbols (index 0) and pattern_length (index 1) on the cfg channel
//   while no byte is in flight; the cfg channel is always ready.
//   Feed one text byte per transfer on the input channel; raise start_of_text on
//   the first byte of each text to drop all partial matches and restart positions.
//   Each byte yields exactly one result transfer: match_found, the earliest start
//   of the match ending at that byte, and whether it is the first match of the text.
// Timing:
//   A row of cells, one per pattern position, advances on every accepted byte;
//   empty quantifier matches ripple along the row in the same cycle.
//   Throughput is one byte per cycle while input ready is high; each result is registered in the output buffer.
// Stall and reset:
//   A two-entry output buffer holds results while the receiver stalls; input
//   ready drops only once both entries are full, and rises as soon as one drains.
//   Reset clears the pattern, positions and match history; without start_of_text
//   the first text begins at position zero with no partial matches.
module regex_substring_match #(
    parameter int PATTERN_SYMBOLS = 8,
    parameter int POSITION_BITS   = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  rsm_pkg::t_rsm_in                      i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output rsm_pkg::t_rsm_out                     o_out_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [rsm_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [rsm_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import rsm_pkg::*;

    localparam int COL_BITS = $clog2(PATTERN_SYMBOLS + 1);

    // Configuration registers
    logic [CFG_DATA_BITS-1:0] r_sym;
    logic [LENGTH_BITS-1:0]   r_len;

    // Text state
    logic [POSITION_BITS-1:0] r_tp;
    logic                     r_ms;

    logic                     w_step, w_clear, w_buf_ready, w_found, w_first, w_ms;
    logic [POSITION_BITS-1:0] w_tp, w_tp_next;
    logic [COL_BITS-1:0]      w_len;
    logic [POSITION_BITS:0]   w_closed [0:PATTERN_SYMBOLS];
    logic [POSITION_BITS:0]   w_cur    [0:PATTERN_SYMBOLS];
    logic [POSITION_BITS:0]   w_hit;
    logic [POSITION_BITS+START_BITS-1:0] w_start_wide;
    t_rsm_out                 w_res;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_buf_ready;
    assign w_step      = i_in_valid && w_buf_ready;
    assign w_clear     = i_in_data.start_of_text;

    // Take a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym <= '0;
            r_len <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_SYMBOLS: r_sym <= i_cfg_data;
                CFG_PATTERN_LENGTH:  r_len <= i_cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the length to the number of cells
    assign w_len = (32'(r_len) > PATTERN_SYMBOLS) ? COL_BITS'(PATTERN_SYMBOLS)
                                                  : COL_BITS'(r_len);

    // Start of a new text drops position and history before this byte
    assign w_tp      = w_clear ? '0 : r_tp;
    assign w_ms      = w_clear ? 1'b0 : r_ms;
    assign w_tp_next = (w_tp == {POSITION_BITS{1'b1}}) ? w_tp
                                                       : w_tp + POSITION_BITS'(1);

    // Column zero: a match may start at the current byte, or just after it
    assign w_closed[0] = {1'b1, w_tp};
    assign w_cur[0]    = {1'b1, w_tp_next};

    generate
        for (genvar j = 1; j <= PATTERN_SYMBOLS; j++) begin : g_col
            t_rsm_sym w_sym;

            if (j - 1 < STORED_SYMBOLS) begin : g_sym
                assign w_sym.sym = r_sym[8*(j-1) +: 8];
            end else begin : g_sym_zero
                assign w_sym.sym = 8'h00;
            end

            if (j >= 2 && j - 2 < STORED_SYMBOLS) begin : g_base
                assign w_sym.base = r_sym[8*(j-2) +: 8];
            end else begin : g_base_zero
                assign w_sym.base = 8'h00;
            end

            // A quantifier in the first position reads as a literal
            assign w_sym.quant_ok = (j >= 2);
            assign w_sym.enable   = (32'(w_len) >= 32'(j));

            if (j >= 2) begin : g_link
                rsm_cell #(
                    .POS_BITS (POSITION_BITS)
                ) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_step   (w_step),
                    .i_clear  (w_clear),
                    .i_sym    (w_sym),
                    .i_char   (i_in_data.text_char),
                    .i_p1     (w_closed[j-1]),
                    .i_p2     (w_closed[j-2]),
                    .i_c2     (w_cur[j-2]),
                    .o_closed (w_closed[j]),
                    .o_cur    (w_cur[j])
                );
            end else begin : g_head
                rsm_cell #(
                    .POS_BITS (POSITION_BITS)
                ) u_cell (
                    .i_clk    (i_clk),
                    .i_rst_n  (i_rst_n),
                    .i_step   (w_step),
                    .i_clear  (w_clear),
                    .i_sym    (w_sym),
                    .i_char   (i_in_data.text_char),
                    .i_p1     (w_closed[j-1]),
                    .i_p2     ('0),
                    .i_c2     ('0),
                    .o_closed (w_closed[j]),
                    .o_cur    (w_cur[j])
                );
            end
        end
    endgenerate

    // Whole pattern matched when the last used column is live
    assign w_hit        = w_cur[w_len];
    assign w_found      = w_hit[POSITION_BITS];
    assign w_first      = w_found && !w_ms;
    assign w_start_wide = {{START_BITS{1'b0}}, w_hit[POSITION_BITS-1:0]};

    always_comb begin
        w_res.match_found     = w_found;
        w_res.match_start     = w_found ? w_start_wide[START_BITS-1:0] : '0;
        w_res.first_match_res = w_first;
    end

    // Advance position and history on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tp <= '0;
            r_ms <= 1'b0;
        end else if (w_step) begin
            r_tp <= w_tp_next;
            r_ms <= w_ms || w_found;
        end
    end

    rsm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_buf_ready),
        .i_data  (w_res),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the streaming pattern matcher, predicting every result transfer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int          COLUMNS      = 9;        // pattern prefixes of length 0 to 8
    localparam int          MAX_LEN      = 8;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam int          STALL_LIMIT  = 2000;     // cycles without any transfer
    localparam int          RANDOM_BYTES = 1400;
    localparam int          LONG_TEXT    = 150;

    // One prefix column: whether a partial match exists and its earliest start
    typedef struct packed {
        bit        ok;
        bit [15:0] at;
    } t_column;

    // Predicts the matcher and checks its result transfers in order
    class t_match_scoreboard;
        bit [63:0] pattern_bytes;
        bit [3:0]  pattern_len;
        t_column   columns[COLUMNS];
        bit [15:0] bytes_seen;
        bit        seen_match;
        t_rsm_out  expected_results[$];
        int        errors;

        function new();
            pattern_bytes = '0;
            pattern_len   = '0;
            errors        = 0;
            restart_text();
        endfunction

        function void restart_text();
            foreach (columns[j]) columns[j] = '0;
            bytes_seen = '0;
            seen_match = 1'b0;
        endfunction

        function void load_register(logic [CFG_INDEX_BITS-1:0] index, logic [63:0] data);
            case (index)
                CFG_PATTERN_SYMBOLS: pattern_bytes = data;
                CFG_PATTERN_LENGTH:  pattern_len   = data[3:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] symbol(int k);
            if (k >= STORED_SYMBOLS) return 8'h00;
            return pattern_bytes[8*k +: 8];
        endfunction

        // A quantifier in the first position is only a literal byte
        function bit is_quantifier(int k);
            bit [7:0] s;
            if (k == 0) return 1'b0;
            s = symbol(k);
            return s == SYM_STAR || s == SYM_OPT || s == SYM_PLUS;
        endfunction

        function bit [15:0] bump(bit [15:0] p);
            return (p == POS_MAX) ? p : p + 16'd1;
        endfunction

        function t_column earliest(t_column a, t_column b);
            if (!b.ok) return a;
            if (!a.ok || b.at < a.at) return b;
            return a;
        endfunction

        // Advance the prefix columns by one text byte and queue the result it must give
        function void note_byte(t_rsm_in item);
            t_column  prev[COLUMNS];
            t_column  cur[COLUMNS];
            int       len;
            bit [7:0] sym;
            bit [7:0] base;
            bit       base_hit;
            t_rsm_out res;
            if (item.start_of_text) restart_text();
            len = (pattern_len > MAX_LEN) ? MAX_LEN : int'(pattern_len);
            for (int j = 0; j < COLUMNS; j++) begin
                prev[j] = columns[j];
                cur[j]  = '0;
            end
            prev[0] = '{ok: 1'b1, at: bytes_seen};
            // close the previous row over empty '*' and '?' occurrences
            for (int j = 2; j <= len; j++) begin
                sym = symbol(j - 1);
                if (is_quantifier(j - 1) && (sym == SYM_STAR || sym == SYM_OPT))
                    prev[j] = earliest(prev[j], prev[j-2]);
            end
            cur[0] = '{ok: 1'b1, at: bump(bytes_seen)};
            for (int j = 1; j <= len; j++) begin
                sym = symbol(j - 1);
                if (!is_quantifier(j - 1)) begin
                    if (sym == SYM_ANY || sym == item.text_char) cur[j] = prev[j-1];
                end else begin
                    base     = symbol(j - 2);
                    base_hit = (base == SYM_ANY || base == item.text_char);
                    case (sym)
                        SYM_STAR: begin
                            cur[j] = cur[j-2];
                            if (base_hit) cur[j] = earliest(cur[j], prev[j]);
                        end
                        SYM_OPT: begin
                            cur[j] = cur[j-2];
                            if (base_hit) cur[j] = earliest(cur[j], prev[j-2]);
                        end
                        default: begin
                            if (base_hit) begin
                                cur[j] = earliest(cur[j], prev[j-2]);
                                cur[j] = earliest(cur[j], prev[j]);
                            end
                        end
                    endcase
                end
            end
            for (int j = 0; j < COLUMNS; j++) columns[j] = cur[j].ok ? cur[j] : '0;
            res.match_found     = cur[len].ok;
            res.match_start     = cur[len].ok ? cur[len].at : 16'd0;
            res.first_match_res = cur[len].ok && !seen_match;
            if (cur[len].ok) seen_match = 1'b1;
            bytes_seen = bump(bytes_seen);
            expected_results.push_back(res);
        endfunction

        function void report_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(t_rsm_out got);
            t_rsm_out want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t result expected none actual %h", $time, got);
                return;
            end
            want = expected_results.pop_front();
            report_field("match_found", want.match_found, got.match_found);
            report_field("match_start", want.match_start, got.match_start);
            report_field("first_match_res", want.first_match_res, got.first_match_res);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    t_rsm_in                   in_data;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    t_rsm_out                  out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    t_match_scoreboard sb;
    bit                steady;        // 1 suppresses idling on both sides
    int                bytes_sent;
    int                idle_cycles;

    regex_substring_match dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample every transfer at the rising edge; note the input before checking the output
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready) sb.load_register(cfg_index, cfg_data);
            if (in_valid && in_ready) sb.note_byte(in_data);
            if (out_valid && out_ready) sb.check_result(out_data);
        end
    end

    // Stall the receiver at random, with a chance of 8 in 100, unless in a steady stretch
    always @(negedge clk) begin
        out_ready = rst_n && (steady || $urandom_range(0, 99) >= 8);
    end

    // Give up once no transfer of any kind has happened for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one text byte; called and returning at a falling edge, valid left high
    task automatic send_byte(input logic [7:0] ch, input logic sot);
        while (!steady && $urandom_range(0, 99) < 8) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid              = 1'b1;
        in_data.text_char     = ch;
        in_data.start_of_text = sot;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic program_register(input logic [CFG_INDEX_BITS-1:0] index,
                                    input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold off until every expected result has arrived and the row has settled
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic configure(input logic [63:0] symbols, input logic [3:0] len);
        drain();
        program_register(CFG_PATTERN_SYMBOLS, symbols);
        program_register(CFG_PATTERN_LENGTH, {60'd0, len});
    endtask

    function automatic logic [63:0] pattern_of(string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < STORED_SYMBOLS; i++) v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Mostly pattern-like symbols so that matches go deep, now and then any byte
    function automatic logic [63:0] random_pattern();
        string       alphabet;
        logic [63:0] v;
        alphabet = "abc.*?+";
        for (int k = 0; k < STORED_SYMBOLS; k++) begin
            if ($urandom_range(0, 99) < 90)
                v[8*k +: 8] = alphabet[$urandom_range(0, 6)];
            else
                v[8*k +: 8] = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    function automatic logic [7:0] random_char();
        string alphabet;
        alphabet = "aabbc.*+?";
        if ($urandom_range(0, 99) < 85) return alphabet[$urandom_range(0, 8)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_string(input string s, input bit fresh);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], fresh && i == 0);
    endtask

    task automatic send_text(input int n, input bit fresh);
        for (int i = 0; i < n; i++) send_byte(random_char(), fresh && i == 0);
    endtask

    initial begin
        logic [63:0] symbols;
        logic [63:0] data;
        logic [3:0]  len;
        int          phase;
        int          random_from;
        int          texts;
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        steady      = 1'b0;
        bytes_sent  = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pattern straight out of reset, no start of text: every byte is an empty match
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Every operator in one pattern, then a text with the optional quantified symbols left out
        configure(pattern_of("a.b*c?d+"), 4'd8);
        send_string("axbbcdd", 1'b1);
        send_string("axd", 1'b1);
        // Leading quantifier as a literal, quantifier quantifying a quantifier
        configure(pattern_of("+a*?"), 4'd4);
        send_string("+a**", 1'b1);
        // Extreme literal bytes, length clamped to eight, upper positions read as zero
        configure({32'h0, SYM_PLUS, SYM_ANY, 8'h00, 8'hFF}, 4'hF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte("q", 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        // Swap the pattern mid text: kept columns carry over
        configure(pattern_of("x*y"), 4'd3);
        send_string("xxy", 1'b0);

        // Random phases: new pattern, then a few texts of random content
        phase       = 0;
        random_from = bytes_sent;
        while (bytes_sent - random_from < RANDOM_BYTES) begin
            drain();
            steady = (phase >= 12 && phase < 22);
            case ($urandom_range(0, 19))
                0:       symbols = '1;
                1:       symbols = '0;
                default: symbols = random_pattern();
            endcase
            len = ($urandom_range(0, 99) < 15) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(1, MAX_LEN));
            // upper bits of the length write are don't-care; exercise them anyway
            data      = {$urandom(), $urandom()};
            data[3:0] = len;
            case ($urandom_range(0, 3))
                0: program_register(CFG_PATTERN_SYMBOLS, symbols);
                1: program_register(CFG_PATTERN_LENGTH, data);
                default: begin
                    program_register(CFG_PATTERN_SYMBOLS, symbols);
                    program_register(CFG_PATTERN_LENGTH, data);
                end
            endcase
            texts = $urandom_range(1, 4);
            for (int t = 0; t < texts; t++)
                send_text($urandom_range(1, 40), !(t == 0 && $urandom_range(0, 3) == 0));
            phase++;
        end
        steady = 1'b0;

        // One longer text, then an empty-match pattern carried on mid text
        configure(pattern_of("ab?"), 4'd3);
        send_text(LONG_TEXT, 1'b1);
        configure(pattern_of("c*"), 4'd2);
        send_text(20, 1'b0);

        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
